### rtl/core/afb_pkg.sv
// Shared types, constants and field layout for the animation frame timer bank.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps

package afb_pkg;

	// Bank geometry
	localparam int SLOTS   = 16;
	localparam int FRAMES  = 64;
	localparam int SLOT_W  = $clog2(SLOTS);
	localparam int FRAME_W = $clog2(FRAMES);
	localparam int ADDR_W  = SLOT_W + FRAME_W;
	localparam int CNT_W   = $clog2(FRAMES + 1);
	localparam int STEP_W  = CNT_W + 1;

	// Field and register widths
	localparam int DELAY_W  = 20;
	localparam int FCOUNT_W = 7;
	localparam int DT_W     = 16;
	localparam int CFG_W    = 16;
	localparam int CFG_IDX_W = 1;
	localparam int ELAP_W   = 21;
	localparam int EL_W     = 22;
	localparam int MCNT_W   = $clog2(EL_W + 1);

	// Input tdata layout, lowest bit first
	localparam int IN_SLOT_LSB  = 0;
	localparam int IN_FI_LSB    = IN_SLOT_LSB + SLOT_W;
	localparam int IN_DELAY_LSB = IN_FI_LSB + FRAME_W;
	localparam int IN_CNT_LSB   = IN_DELAY_LSB + DELAY_W;
	localparam int IN_DT_LSB    = IN_CNT_LSB + FCOUNT_W;
	localparam int IN_W         = 56;

	// Output tdata layout, lowest bit first
	localparam int OUT_SLOT_LSB  = 0;
	localparam int OUT_FRAME_LSB = OUT_SLOT_LSB + SLOT_W;
	localparam int OUT_ADV_BIT   = OUT_FRAME_LSB + FRAME_W;
	localparam int OUT_ANY_BIT   = OUT_ADV_BIT + 1;
	localparam int OUT_W         = 16;

	// Register reset values
	localparam logic [CFG_W-1:0] MIN_DELAY_RST = 16'd20;
	localparam logic [CFG_W-1:0] DEF_DELAY_RST = 16'd100;

	typedef enum logic [1:0] {
		OP_LOAD  = 2'd0,
		OP_START = 2'd1,
		OP_STOP  = 2'd2,
		OP_TICK  = 2'd3
	} op_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_MIN_DELAY = 1'b0,
		REG_DEF_DELAY = 1'b1
	} reg_idx_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SETUP,
		ST_READ,
		ST_CMP,
		ST_MOD_GO,
		ST_MOD_WAIT,
		ST_EMIT
	} state_t;

	// Controller to datapath
	typedef struct packed {
		logic in_ready;
		logic accept;
		logic setup;
		logic rd;
		logic step;
		logic mod_start;
		logic mod_take;
		logic emit;
	} cmd_t;

	// Datapath to controller
	typedef struct packed {
		logic in_valid;
		logic in_tick;
		logic run;
		logic ge;
		logic hit;
		logic mod_busy;
		logic mod_done;
		logic out_free;
		logic last_slot;
	} sts_t;

endpackage

### rtl/core/animation_frame_timer_bank.sv
// Animation frame timer bank: load, start and stop are accepted back to back.
// A tick is accepted and then sweeps every slot: an idle slot is set up and emitted; a running
// slot steps frame by frame through a read and a compare, and uses the bit-serial remainder unit
// when its elapsed time spans a whole animation cycle; each result is registered, and stalls hold it.
// Asynchronous active-low reset clears slot state, active flags and control, sets the
// registers to 20 and 100; the delay memory is not cleared and needs no clearing pass.
`timescale 1ns / 1ps

module animation_frame_timer_bank (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          s_tvalid,
	output logic                          s_tready,
	// slot[3:0], frame_index[9:4], delay_ms[29:10], frame_count[36:30], dt_ms[52:37]
	input  logic [afb_pkg::IN_W-1:0]      s_tdata,
	// op[1:0]
	input  logic [1:0]                    s_tuser,
	output logic                          m_tvalid,
	input  logic                          m_tready,
	// slot_id[3:0], shown_frame[9:4], advanced[10], any_changed[11]
	output logic [afb_pkg::OUT_W-1:0]     m_tdata,
	output logic                          m_tlast,
	input  logic                          cfg_we,
	input  logic [afb_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [afb_pkg::CFG_W-1:0]     cfg_wdata
);
	import afb_pkg::*;

	cmd_t cmd;
	sts_t sts;

	afb_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.sts    (sts),
		.cmd    (cmd)
	);

	afb_datapath u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.sts       (sts),
		.s_tvalid  (s_tvalid),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tlast   (m_tlast),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata)
	);

	assign s_tready = cmd.in_ready;

	// Never load the output register over a result not yet transferred
	a_emit_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit |-> sts.out_free)
		else $error("result emitted over a pending transfer");

	// Never restart the remainder unit while it is working
	a_mod_idle: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.mod_start |-> !sts.mod_busy)
		else $error("remainder unit restarted while busy");

	// The final result of a tick reports on the highest slot
	a_last_slot: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tlast) |->
			(m_tdata[OUT_SLOT_LSB +: SLOT_W] == SLOT_W'(SLOTS - 1)))
		else $error("last result not on the final slot");

	// The changed flag appears only on the final result
	a_any_last: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tdata[OUT_ANY_BIT]) |-> m_tlast)
		else $error("changed flag on an earlier result");

endmodule

### rtl/core/afb_mod_unit.sv
// Iterative restoring remainder unit, one quotient bit per cycle.
// Depends on afb_pkg for the operand width.
`timescale 1ns / 1ps

module afb_mod_unit (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     start,
	input  logic [afb_pkg::EL_W-1:0] dividend,
	input  logic [afb_pkg::EL_W-1:0] divisor,
	output logic                     busy,
	output logic                     done,
	output logic [afb_pkg::EL_W-1:0] rem
);
	import afb_pkg::*;

	logic              busy_q;
	logic              done_q;
	logic [MCNT_W-1:0] cnt_q;
	logic [EL_W-1:0]   rem_q;
	logic [EL_W-1:0]   dvd_q;
	logic [EL_W-1:0]   div_q;
	logic [EL_W:0]     trial;
	logic [EL_W:0]     rem_n;

	// Shift in the next dividend bit and subtract the divisor where it fits
	always_comb begin
		trial = {rem_q, dvd_q[EL_W-1]};
		if (trial >= {1'b0, div_q}) begin
			rem_n = trial - {1'b0, div_q};
		end else begin
			rem_n = trial;
		end
	end

	// Control: count the steps and flag completion for one cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= MCNT_W'(EL_W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == MCNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// Operand and partial remainder
	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			dvd_q <= dividend;
			div_q <= divisor;
		end else if (busy_q) begin
			rem_q <= rem_n[EL_W-1:0];
			dvd_q <= {dvd_q[EL_W-2:0], 1'b0};
		end
	end

	assign busy = busy_q;
	assign done = done_q;
	assign rem  = rem_q;

endmodule

### rtl/core/afb_datapath.sv
// Datapath: delay memory, per-slot timing state, step arithmetic and output register.
// Depends on afb_pkg and afb_mod_unit.
`timescale 1ns / 1ps

module afb_datapath (
	input  logic                            clk,
	input  logic                            arst_n,
	input  afb_pkg::cmd_t                   cmd,
	output afb_pkg::sts_t                   sts,
	input  logic                            s_tvalid,
	input  logic [afb_pkg::IN_W-1:0]        s_tdata,
	input  logic [1:0]                      s_tuser,
	output logic                            m_tvalid,
	input  logic                            m_tready,
	output logic [afb_pkg::OUT_W-1:0]       m_tdata,
	output logic                            m_tlast,
	input  logic                            cfg_we,
	input  logic [afb_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [afb_pkg::CFG_W-1:0]       cfg_wdata
);
	import afb_pkg::*;

	// Input field views
	logic [SLOT_W-1:0]   in_slot;
	logic [FRAME_W-1:0]  in_fi;
	logic [DELAY_W-1:0]  in_delay;
	logic [FCOUNT_W-1:0] in_count;
	logic [DT_W-1:0]     in_dt;
	op_t                 in_op;

	// Configuration
	logic [CFG_W-1:0] min_delay_q;
	logic [CFG_W-1:0] def_delay_q;

	// Slot tables
	logic [CNT_W-1:0]   fcount_q  [SLOTS];
	logic [FRAME_W-1:0] cur_q     [SLOTS];
	logic [ELAP_W-1:0]  elapsed_q [SLOTS];
	logic [SLOTS-1:0]   active_q;

	// Delay memory
	logic [DELAY_W-1:0] delay_mem [SLOTS * FRAMES];
	logic [DELAY_W-1:0] rd_q;
	logic [DELAY_W-1:0] store_delay;

	// Working registers of the slot under way
	logic [DT_W-1:0]    dt_q;
	logic [SLOT_W-1:0]  idx_q;
	logic [EL_W-1:0]    el_q;
	logic [EL_W-1:0]    acc_q;
	logic [FRAME_W-1:0] fr_q;
	logic [STEP_W-1:0]  steps_q;
	logic               moved_q;
	logic               mod_done_q;
	logic               run_q;
	logic               any_q;

	// Output register
	logic               out_valid_q;
	logic [OUT_W-1:0]   out_data_q;
	logic               out_last_q;

	logic               apply;
	logic               run_now;
	logic [CNT_W-1:0]   cnt_cur;
	logic [DELAY_W-1:0] eff;
	logic [EL_W-1:0]    eff_ext;
	logic [CNT_W-1:0]   fr_inc;
	logic [FRAME_W-1:0] fr_next;
	logic               last_slot;
	logic               any_final;
	logic               mod_busy;
	logic               mod_done;
	logic [EL_W-1:0]    mod_rem;

	assign in_slot  = s_tdata[IN_SLOT_LSB +: SLOT_W];
	assign in_fi    = s_tdata[IN_FI_LSB +: FRAME_W];
	assign in_delay = s_tdata[IN_DELAY_LSB +: DELAY_W];
	assign in_count = s_tdata[IN_CNT_LSB +: FCOUNT_W];
	assign in_dt    = s_tdata[IN_DT_LSB +: DT_W];
	assign in_op    = op_t'(s_tuser);

	// Load, start and stop act on the transfer itself
	assign apply = cmd.accept && (in_op != OP_TICK) && ({1'b0, in_slot} < (SLOT_W + 1)'(SLOTS));

	// Replace delays under the minimum by the default
	assign store_delay = (in_delay < {{(DELAY_W - CFG_W){1'b0}}, min_delay_q})
		? {{(DELAY_W - CFG_W){1'b0}}, def_delay_q} : in_delay;

	// Step arithmetic: a stored zero is timed as one
	assign cnt_cur = fcount_q[idx_q];
	assign run_now = active_q[idx_q] && (cnt_cur >= CNT_W'(2));
	assign eff     = (rd_q == '0) ? DELAY_W'(1) : rd_q;
	assign eff_ext = {{(EL_W - DELAY_W){1'b0}}, eff};
	assign fr_inc  = {{(CNT_W - FRAME_W){1'b0}}, fr_q} + 1'b1;
	assign fr_next = (fr_inc >= cnt_cur) ? '0 : fr_inc[FRAME_W-1:0];
	assign last_slot = (idx_q == SLOT_W'(SLOTS - 1));
	assign any_final = any_q || moved_q;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_delay_q <= MIN_DELAY_RST;
			def_delay_q <= DEF_DELAY_RST;
		end else if (cfg_we) begin
			case (reg_idx_t'(cfg_index))
				REG_MIN_DELAY: min_delay_q <= cfg_wdata;
				REG_DEF_DELAY: def_delay_q <= cfg_wdata;
				default: ;
			endcase
		end
	end

	// Delay memory: write on load, registered read for the step compare
	always_ff @(posedge clk) begin
		if (apply && (in_op == OP_LOAD) && ({1'b0, in_fi} < (FRAME_W + 1)'(FRAMES))) begin
			delay_mem[{in_slot, in_fi}] <= store_delay;
		end
		if (cmd.rd) begin
			rd_q <= delay_mem[{idx_q, fr_q}];
		end
	end

	// Slot tables: start and stop from the input, write back at the end of a slot
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < SLOTS; i++) begin
				fcount_q[i]  <= '0;
				cur_q[i]     <= '0;
				elapsed_q[i] <= '0;
			end
			active_q <= '0;
		end else begin
			if (apply && (in_op == OP_START)) begin
				fcount_q[in_slot]  <= (in_count > FCOUNT_W'(FRAMES))
					? CNT_W'(FRAMES) : CNT_W'(in_count);
				cur_q[in_slot]     <= '0;
				elapsed_q[in_slot] <= '0;
				active_q[in_slot]  <= 1'b1;
			end else if (apply && (in_op == OP_STOP)) begin
				active_q[in_slot]  <= 1'b0;
			end
			if (cmd.emit && run_q) begin
				cur_q[idx_q]     <= fr_q;
				elapsed_q[idx_q] <= el_q[ELAP_W-1:0];
			end
		end
	end

	// Sweep control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q      <= '0;
			any_q      <= 1'b0;
			run_q      <= 1'b0;
			moved_q    <= 1'b0;
			mod_done_q <= 1'b0;
			steps_q    <= '0;
		end else begin
			if (cmd.accept && (in_op == OP_TICK)) begin
				idx_q <= '0;
				any_q <= 1'b0;
			end
			if (cmd.setup) begin
				run_q      <= run_now;
				moved_q    <= 1'b0;
				mod_done_q <= 1'b0;
				steps_q    <= '0;
			end
			if (cmd.step) begin
				moved_q <= 1'b1;
				steps_q <= steps_q + 1'b1;
			end
			if (cmd.mod_take) begin
				mod_done_q <= 1'b1;
			end
			if (cmd.emit) begin
				any_q <= any_final;
				idx_q <= idx_q + 1'b1;
			end
		end
	end

	// Elapsed time, consumed sum and frame of the slot under way
	always_ff @(posedge clk) begin
		if (cmd.accept && (in_op == OP_TICK)) begin
			dt_q <= in_dt;
		end
		if (cmd.setup) begin
			el_q  <= {1'b0, elapsed_q[idx_q]} + {{(EL_W - DT_W){1'b0}}, dt_q};
			acc_q <= '0;
			fr_q  <= cur_q[idx_q];
		end else if (cmd.step) begin
			el_q  <= el_q - eff_ext;
			acc_q <= acc_q + eff_ext;
			fr_q  <= fr_next;
		end else if (cmd.mod_take) begin
			el_q  <= mod_rem;
		end
	end

	// Remove whole animation cycles once a full cycle has been consumed
	afb_mod_unit u_mod (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmd.mod_start),
		.dividend (el_q),
		.divisor  (acc_q),
		.busy     (mod_busy),
		.done     (mod_done),
		.rem      (mod_rem)
	);

	// Output register: hold until the transfer, load on emit
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.emit) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			out_data_q <= {{(OUT_W - OUT_ANY_BIT - 1){1'b0}}, last_slot && any_final,
				moved_q, fr_q, idx_q};
			out_last_q <= last_slot;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_data_q;
	assign m_tlast  = out_last_q;

	// Status towards the controller
	always_comb begin
		sts.in_valid  = s_tvalid;
		sts.in_tick   = (in_op == OP_TICK);
		sts.run       = run_now;
		sts.ge        = (el_q >= eff_ext);
		sts.hit       = !mod_done_q && (steps_q + 1'b1 == {1'b0, cnt_cur});
		sts.mod_busy  = mod_busy;
		sts.mod_done  = mod_done;
		sts.out_free  = !out_valid_q || m_tready;
		sts.last_slot = last_slot;
	end

endmodule

### rtl/core/afb_ctrl.sv
// Controller state machine: sweeps the slots on a tick and sequences the steps.
// Depends on afb_pkg.
`timescale 1ns / 1ps

module afb_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  afb_pkg::sts_t sts,
	output afb_pkg::cmd_t cmd
);
	import afb_pkg::*;

	state_t state_q;
	state_t state_n;

	// State register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_n;
		end
	end

	// Next state and commands
	always_comb begin
		state_n = state_q;
		cmd     = '0;
		case (state_q)
			ST_IDLE: begin
				cmd.in_ready = 1'b1;
				if (sts.in_valid) begin
					cmd.accept = 1'b1;
					if (sts.in_tick) begin
						state_n = ST_SETUP;
					end
				end
			end
			ST_SETUP: begin
				cmd.setup = 1'b1;
				state_n   = sts.run ? ST_READ : ST_EMIT;
			end
			ST_READ: begin
				cmd.rd  = 1'b1;
				state_n = ST_CMP;
			end
			ST_CMP: begin
				if (sts.ge) begin
					cmd.step = 1'b1;
					state_n  = sts.hit ? ST_MOD_GO : ST_READ;
				end else begin
					state_n = ST_EMIT;
				end
			end
			ST_MOD_GO: begin
				cmd.mod_start = 1'b1;
				state_n       = ST_MOD_WAIT;
			end
			ST_MOD_WAIT: begin
				if (sts.mod_done) begin
					cmd.mod_take = 1'b1;
					state_n      = ST_READ;
				end
			end
			ST_EMIT: begin
				if (sts.out_free) begin
					cmd.emit = 1'b1;
					state_n  = sts.last_slot ? ST_IDLE : ST_SETUP;
				end
			end
			default: begin
				state_n = ST_IDLE;
			end
		endcase
	end

endmodule

### tb/testbench.sv
// Self-checking testbench for the animation frame timer bank.
// Drives load, start, stop and tick transfers, predicts every tick result and checks them.
// Depends on afb_pkg and animation_frame_timer_bank only.
`timescale 1ns / 1ps

module testbench;
	import afb_pkg::*;

	localparam int CYCLE_LIMIT   = 4000000;
	localparam int SETTLE_CYCLES = 60;
	localparam int HOLD_CYCLES   = 1500;
	localparam int SEGMENT_ITEMS = 43;

	typedef struct packed {
		logic       last;
		logic       any;
		logic       adv;
		logic [5:0] shown;
		logic [3:0] slot_id;
	} frame_result_t;

	// Directed row: tick rows carry the expected frame and advance flag of slots 0 and 15;
	// every other slot is expected at frame 0 without advancing
	typedef struct packed {
		op_t        op;
		logic [3:0] slot;
		logic [5:0] fi;
		logic [19:0] delay;
		logic [6:0] count;
		logic [15:0] dt;
		logic [5:0] f0;
		logic       a0;
		logic [5:0] f15;
		logic       a15;
		logic       any;
	} stim_row_t;

	stim_row_t directed_rows [22] = '{
		'{OP_TICK,  4'd0,  6'd0,  20'd0,       7'd0, 16'd0,      6'd0, 1'b0, 6'd0, 1'b0, 1'b0},
		'{OP_LOAD,  4'd0,  6'd0,  20'd10,      7'd0, 16'd0,      6'd0, 1'b0, 6'd0, 1'b0, 1'b0},
		'{OP_LOAD,  4'd0,  6'd1,  20'd20,      7'd0, 16'd0,      6'd0, 1'b0, 6'd0, 1'b0, 1'b0},
		'{OP_LOAD,  4'd0,  6'd2,  20'hFFFFF,   7'd0, 16'd0,      6'd0, 1'b0, 6'd0, 1'b0, 1'b0},
		'{OP_START, 4'd0,  6'd0,  20'd0,       7'd3, 16'd0,      6'd0, 1'b0, 6'd0, 1'b0, 1'b0},
		'{OP_TICK,  4'd0,  6'd0,  20'd0,       7'd0, 16'd99,     6'd0, 1'b0, 6'd0, 1'b0, 1'b0},
		'{OP_TICK,  4'd0,  6'd0,  20'd0,       7'd0, 16'd1,      6'd1, 1'b1, 6'd0, 1'b0, 1'b1},
		'{OP_TICK,  4'd0,  6'd0,  20'd0,       7'd0, 16'd20,     6'd2, 1'b1, 6'd0, 1'b0, 1'b1},
		'{OP_TICK,  4'd0,  6'd0,  20'd0,       7'd0, 16'hFFFF,   6'd2, 1'b0, 6'd0, 1'b0, 1'b0},
		'{OP_LOAD,  4'd15, 6'd0,  20'd30,      7'd0, 16'd0,      6'd0, 1'b0, 6'd0, 1'b0, 1'b0},
		'{OP_LOAD,  4'd15, 6'd1,  20'd30,      7'd0, 16'd0,      6'd0, 1'b0, 6'd0, 1'b0, 1'b0},
		'{OP_LOAD,  4'd15, 6'd63, 20'd0,       7'd0, 16'd0,      6'd0, 1'b0, 6'd0, 1'b0, 1'b0},
		'{OP_START, 4'd15, 6'd0,  20'd0,       7'd2, 16'd0,      6'd0, 1'b0, 6'd0, 1'b0, 1'b0},
		'{OP_START, 4'd14, 6'd0,  20'd0,       7'd1, 16'd0,      6'd0, 1'b0, 6'd0, 1'b0, 1'b0},
		'{OP_TICK,  4'd0,  6'd0,  20'd0,       7'd0, 16'hFFFF,   6'd2, 1'b0, 6'd0, 1'b1, 1'b1},
		'{OP_TICK,  4'd0,  6'd0,  20'd0,       7'd0, 16'd15,     6'd2, 1'b0, 6'd1, 1'b1, 1'b1},
		'{OP_STOP,  4'd15, 6'd0,  20'd0,       7'd0, 16'd0,      6'd0, 1'b0, 6'd0, 1'b0, 1'b0},
		'{OP_TICK,  4'd0,  6'd0,  20'd0,       7'd0, 16'd100,    6'd2, 1'b0, 6'd1, 1'b0, 1'b0},
		'{OP_START, 4'd0,  6'd0,  20'd0,       7'd3, 16'd0,      6'd0, 1'b0, 6'd0, 1'b0, 1'b0},
		'{OP_TICK,  4'd0,  6'd0,  20'd0,       7'd0, 16'd120,    6'd2, 1'b1, 6'd1, 1'b0, 1'b1},
		'{OP_START, 4'd13, 6'd0,  20'd0,       7'd0, 16'd0,      6'd0, 1'b0, 6'd0, 1'b0, 1'b0},
		'{OP_TICK,  4'd0,  6'd0,  20'd0,       7'd0, 16'd0,      6'd2, 1'b0, 6'd1, 1'b0, 1'b0}
	};

	logic              clk;
	logic              arst_n;
	logic              s_tvalid;
	logic              s_tready;
	logic [IN_W-1:0]   s_tdata;
	logic [1:0]        s_tuser;
	logic              m_tvalid;
	logic              m_tready;
	logic [OUT_W-1:0]  m_tdata;
	logic              m_tlast;
	logic              cfg_we;
	reg_idx_t          cfg_index;
	logic [CFG_W-1:0]  cfg_wdata;

	// Predicted state of the bank
	logic [DELAY_W-1:0]  bank_delay [SLOTS][FRAMES];
	bit                  delay_loaded [SLOTS][FRAMES];
	logic [FCOUNT_W-1:0] bank_count [SLOTS];
	logic [FRAME_W-1:0]  bank_frame [SLOTS];
	logic [ELAP_W-1:0]   bank_elapsed [SLOTS];
	bit                  bank_active [SLOTS];
	logic [CFG_W-1:0]    min_delay;
	logic [CFG_W-1:0]    def_delay;

	frame_result_t pending_results [$];
	stim_row_t     typed_row;
	bit            typed_on;

	int tx_idle_pct;
	int rx_idle_pct;
	int hold_requests;
	int holds_started;
	int hold_left;
	int items_sent;
	int ticks_sent;
	int results_checked;
	int mismatches;
	int cycle_count;

	animation_frame_timer_bank i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tlast   (m_tlast),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata)
	);

	// Clock and run limit
	initial clk = 1'b0;
	always #5 clk = ~clk;

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("%0t: run limit of %0d cycles reached", $time, CYCLE_LIMIT);
			$display("FAIL");
			$finish;
		end
	end

	// A zero delay is timed as one millisecond
	function automatic int unsigned timed_delay(int s, int f);
		return (bank_delay[s][f] == '0) ? 1 : 32'(bank_delay[s][f]);
	endfunction

	// Advance every running slot by dt and queue one result per slot
	task automatic predict_tick(input logic [DT_W-1:0] dt);
		int unsigned period;
		int unsigned el;
		int unsigned n;
		int unsigned cur;
		bit moved [SLOTS];
		bit any_moved;
		frame_result_t r;
		any_moved = 1'b0;
		for (int s = 0; s < SLOTS; s++) begin
			moved[s] = 1'b0;
			if (bank_active[s] && bank_count[s] >= 2) begin
				n = 32'(bank_count[s]);
				cur = 32'(bank_frame[s]);
				el = 32'(bank_elapsed[s]) + 32'(dt);
				period = 0;
				for (int f = 0; f < n; f++)
					period += timed_delay(s, f);
				// drop whole animation cycles at once
				if (el >= period) begin
					el = el % period;
					moved[s] = 1'b1;
				end
				while (el >= timed_delay(s, cur)) begin
					el -= timed_delay(s, cur);
					cur = (cur + 1 >= n) ? 0 : cur + 1;
					moved[s] = 1'b1;
				end
				bank_frame[s] = FRAME_W'(cur);
				bank_elapsed[s] = ELAP_W'(el);
			end
			any_moved |= moved[s];
		end
		for (int s = 0; s < SLOTS; s++) begin
			r.slot_id = SLOT_W'(s);
			r.last = (s == SLOTS - 1);
			if (typed_on) begin
				r.shown = (s == 0) ? typed_row.f0 : (s == SLOTS - 1) ? typed_row.f15 : '0;
				r.adv = (s == 0) ? typed_row.a0 : (s == SLOTS - 1) ? typed_row.a15 : 1'b0;
				r.any = (s == SLOTS - 1) ? typed_row.any : 1'b0;
			end else begin
				r.shown = bank_frame[s];
				r.adv = moved[s];
				r.any = (s == SLOTS - 1) ? any_moved : 1'b0;
			end
			pending_results.push_back(r);
		end
	endtask

	// Apply one accepted item to the predicted state
	task automatic predict_item(input op_t op, input logic [3:0] slot, input logic [5:0] fi,
			input logic [DELAY_W-1:0] delay, input logic [FCOUNT_W-1:0] count,
			input logic [DT_W-1:0] dt);
		case (op)
			OP_LOAD: begin
				bank_delay[slot][fi] = (delay < min_delay) ? DELAY_W'(def_delay) : delay;
				delay_loaded[slot][fi] = 1'b1;
			end
			OP_START: begin
				bank_count[slot] = (count > FRAMES) ? FCOUNT_W'(FRAMES) : count;
				bank_frame[slot] = '0;
				bank_elapsed[slot] = '0;
				bank_active[slot] = 1'b1;
			end
			OP_STOP: begin
				bank_active[slot] = 1'b0;
			end
			default: begin
				predict_tick(dt);
			end
		endcase
	endtask

	// Offer one item after a random gap and hold it until the transfer completes
	task automatic send_item(input op_t op, input logic [3:0] slot, input logic [5:0] fi,
			input logic [DELAY_W-1:0] delay, input logic [FCOUNT_W-1:0] count,
			input logic [DT_W-1:0] dt);
		logic [IN_W-1:0] d;
		while ($urandom_range(0, 99) < tx_idle_pct) begin
			s_tvalid = 1'b0;
			@(negedge clk);
		end
		d = '0;
		d[IN_SLOT_LSB +: SLOT_W] = slot;
		d[IN_FI_LSB +: FRAME_W] = fi;
		d[IN_DELAY_LSB +: DELAY_W] = delay;
		d[IN_CNT_LSB +: FCOUNT_W] = count;
		d[IN_DT_LSB +: DT_W] = dt;
		s_tdata = d;
		s_tuser = op;
		s_tvalid = 1'b1;
		do
			@(posedge clk);
		while (!s_tready);
		predict_item(op, slot, fi, delay, count, dt);
		items_sent++;
		if (op == OP_TICK)
			ticks_sent++;
		@(negedge clk);
	endtask

	// Wait until every queued result has arrived and the block has settled
	task automatic drain();
		s_tvalid = 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
		@(negedge clk);
	endtask

	task automatic write_reg(input reg_idx_t idx, input logic [CFG_W-1:0] value);
		cfg_index = idx;
		cfg_wdata = value;
		cfg_we = 1'b1;
		@(negedge clk);
		cfg_we = 1'b0;
		if (idx == REG_MIN_DELAY)
			min_delay = value;
		else
			def_delay = value;
		@(negedge clk);
	endtask

	function automatic logic [DELAY_W-1:0] random_delay();
		int unsigned p;
		p = $urandom_range(0, 99);
		if (p < 50)
			return DELAY_W'($urandom_range(0, 200));
		else if (p < 75)
			return DELAY_W'($urandom_range(0, 40));
		else if (p < 90)
			return DELAY_W'($urandom_range(200, 5000));
		return DELAY_W'($urandom());
	endfunction

	function automatic logic [DT_W-1:0] random_dt();
		int unsigned p;
		p = $urandom_range(0, 99);
		if (p < 60)
			return DT_W'($urandom_range(0, 150));
		else if (p < 85)
			return DT_W'($urandom_range(0, 1000));
		return DT_W'($urandom());
	endfunction

	// Load the frames a slot needs, start it and let time pass; unused fields carry noise
	task automatic play_animation();
		int s;
		int n;
		int nf;
		int p;
		s = $urandom_range(0, SLOTS - 1);
		p = $urandom_range(0, 99);
		if (p < 70)
			n = $urandom_range(2, 6);
		else if (p < 85)
			n = $urandom_range(0, 1);
		else if (p < 96)
			n = $urandom_range(7, FRAMES);
		else
			n = $urandom_range(FRAMES + 1, 127);
		nf = (n > FRAMES) ? FRAMES : n;
		for (int f = 0; f < nf; f++)
			if (!delay_loaded[s][f] || $urandom_range(0, 2) == 0)
				send_item(OP_LOAD, SLOT_W'(s), FRAME_W'(f), random_delay(),
					FCOUNT_W'($urandom()), DT_W'($urandom()));
		if ($urandom_range(0, 3) == 0)
			send_item(OP_LOAD, SLOT_W'($urandom()), FRAME_W'($urandom()), random_delay(),
				FCOUNT_W'($urandom()), DT_W'($urandom()));
		if ($urandom_range(0, 7) == 0)
			send_item(OP_STOP, SLOT_W'($urandom()), FRAME_W'($urandom()),
				DELAY_W'($urandom()), FCOUNT_W'($urandom()), DT_W'($urandom()));
		send_item(OP_START, SLOT_W'(s), FRAME_W'($urandom()), DELAY_W'($urandom()),
			FCOUNT_W'(n), DT_W'($urandom()));
		repeat ($urandom_range(1, 4))
			send_item(OP_TICK, SLOT_W'($urandom()), FRAME_W'($urandom()),
				DELAY_W'($urandom()), FCOUNT_W'($urandom()), random_dt());
		if ($urandom_range(0, 4) == 0)
			send_item(OP_STOP, SLOT_W'(s), FRAME_W'($urandom()), DELAY_W'($urandom()),
				FCOUNT_W'($urandom()), DT_W'($urandom()));
	endtask

	// Result sink: random stalls, plus a long hold-off on request
	always @(negedge clk) begin
		if (hold_requests != holds_started) begin
			holds_started = hold_requests;
			hold_left = HOLD_CYCLES;
		end
		if (hold_left > 0) begin
			hold_left--;
			m_tready = 1'b0;
		end else begin
			m_tready = ($urandom_range(0, 99) >= rx_idle_pct);
		end
	end

	// Check each result transfer against the oldest expectation
	always @(posedge clk) begin
		frame_result_t got;
		frame_result_t want;
		if (arst_n && m_tvalid && m_tready) begin
			got.slot_id = m_tdata[OUT_SLOT_LSB +: SLOT_W];
			got.shown = m_tdata[OUT_FRAME_LSB +: FRAME_W];
			got.adv = m_tdata[OUT_ADV_BIT];
			got.any = m_tdata[OUT_ANY_BIT];
			got.last = m_tlast;
			if (pending_results.size() == 0) begin
				mismatches++;
				$display("%0t: result with none expected: slot %0d frame %0d adv %0d any %0d last %0d",
					$time, got.slot_id, got.shown, got.adv, got.any, got.last);
			end else begin
				want = pending_results.pop_front();
				results_checked++;
				if (got !== want) begin
					mismatches++;
					$display("%0t: mismatch: expected slot %0d frame %0d adv %0d any %0d last %0d",
						$time, want.slot_id, want.shown, want.adv, want.any, want.last);
					$display("%0t:           actual slot %0d frame %0d adv %0d any %0d last %0d",
						$time, got.slot_id, got.shown, got.adv, got.any, got.last);
				end
			end
		end
	end

	// Stimulus
	initial begin
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		s_tuser = OP_LOAD;
		m_tready = 1'b0;
		cfg_we = 1'b0;
		cfg_index = REG_MIN_DELAY;
		cfg_wdata = '0;
		hold_requests = 0;
		holds_started = 0;
		hold_left = 0;
		tx_idle_pct = 10;
		rx_idle_pct = 69;
		items_sent = 0;
		ticks_sent = 0;
		results_checked = 0;
		mismatches = 0;
		cycle_count = 0;
		typed_on = 1'b0;
		min_delay = MIN_DELAY_RST;
		def_delay = DEF_DELAY_RST;
		for (int s = 0; s < SLOTS; s++) begin
			bank_count[s] = '0;
			bank_frame[s] = '0;
			bank_elapsed[s] = '0;
			bank_active[s] = 1'b0;
			for (int f = 0; f < FRAMES; f++) begin
				bank_delay[s][f] = '0;
				delay_loaded[s][f] = 1'b0;
			end
		end
		repeat (10) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// Directed table with expected tick results typed in
		typed_on = 1'b1;
		foreach (directed_rows[i]) begin
			typed_row = directed_rows[i];
			send_item(typed_row.op, typed_row.slot, typed_row.fi, typed_row.delay,
				typed_row.count, typed_row.dt);
		end
		typed_on = 1'b0;

		// Random phases across register settings and idle patterns
		for (int phase = 0; phase < 6; phase++) begin
			drain();
			tx_idle_pct = (phase < 2) ? 10 : (phase < 4) ? 69 : 0;
			rx_idle_pct = (phase < 2) ? 69 : (phase < 4) ? 10 : 0;
			case (phase)
				1: begin
					write_reg(REG_MIN_DELAY, 16'd0);
					write_reg(REG_DEF_DELAY, 16'd1);
				end
				2: begin
					write_reg(REG_MIN_DELAY, 16'hFFFF);
					write_reg(REG_DEF_DELAY, 16'd0);
				end
				3: begin
					write_reg(REG_MIN_DELAY, 16'd1);
					write_reg(REG_DEF_DELAY, 16'hFFFF);
				end
				4: begin
					write_reg(REG_MIN_DELAY, CFG_W'($urandom_range(1, 300)));
					write_reg(REG_DEF_DELAY, CFG_W'($urandom_range(1, 300)));
				end
				5: begin
					write_reg(REG_MIN_DELAY, MIN_DELAY_RST);
					write_reg(REG_DEF_DELAY, DEF_DELAY_RST);
					// hold the sink off while ticks keep coming, so the input backs up
					hold_requests++;
					repeat (8)
						send_item(OP_TICK, SLOT_W'($urandom()), FRAME_W'($urandom()),
							DELAY_W'($urandom()), FCOUNT_W'($urandom()), random_dt());
				end
				default: begin
				end
			endcase
			begin
				int phase_start;
				phase_start = items_sent;
				while (items_sent - phase_start < SEGMENT_ITEMS)
					play_animation();
			end
		end
		drain();

		$display("Sent %0d items (%0d ticks) over six phases of register settings and idle patterns;",
			items_sent, ticks_sent);
		$display("checked %0d results, %0d mismatches.", results_checked, mismatches);
		if (mismatches == 0 && pending_results.size() == 0) begin
			$display("PASS");
		end else begin
			$display("FAIL");
		end
		$finish;
	end

endmodule
